/* rtl/assert_macros.svh */
// Assertion macros used by the scanner RTL.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/stsc_pkg.sv */
package stsc_pkg;

   // Length limit for words, numbers and arrows, and the widths that follow.
   localparam int MAX_TOKEN_LENGTH = 64;
   localparam int RUN_W            = $clog2(MAX_TOKEN_LENGTH + 2);
   localparam int LEN_W            = 7;

   localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_TOKEN_LENGTH);
   localparam logic [30:0]      VALUE_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0]      POS_MAX   = 16'hFFFF;

   // Output staging: one result slot per possible result of a byte, plus one.
   localparam int OUT_SLOTS = 4;
   localparam int CNT_W     = $clog2(OUT_SLOTS + 1);

   // Characters with a special role.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_EQ      = 8'h3D;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_PIPE    = 8'h7C;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   // Marker returned when a character cannot start a two-character operator.
   localparam logic [8:0] NO_PAIR = 9'h100;

   // Token kind codes.
   localparam logic [5:0] KIND_SEMI    = 6'd0;
   localparam logic [5:0] KIND_COLON   = 6'd1;
   localparam logic [5:0] KIND_COMMA   = 6'd2;
   localparam logic [5:0] KIND_LPAREN  = 6'd3;
   localparam logic [5:0] KIND_RPAREN  = 6'd4;
   localparam logic [5:0] KIND_LBRACE  = 6'd5;
   localparam logic [5:0] KIND_RBRACE  = 6'd6;
   localparam logic [5:0] KIND_LBRACK  = 6'd7;
   localparam logic [5:0] KIND_RBRACK  = 6'd8;
   localparam logic [5:0] KIND_AT      = 6'd9;
   localparam logic [5:0] KIND_ARROW   = 6'd10;
   localparam logic [5:0] KIND_MINUS   = 6'd11;
   localparam logic [5:0] KIND_PLUS    = 6'd12;
   localparam logic [5:0] KIND_STAR    = 6'd13;
   localparam logic [5:0] KIND_SLASH   = 6'd14;
   localparam logic [5:0] KIND_PERCENT = 6'd15;
   localparam logic [5:0] KIND_XOR2    = 6'd16;
   localparam logic [5:0] KIND_GE      = 6'd17;
   localparam logic [5:0] KIND_GT      = 6'd18;
   localparam logic [5:0] KIND_LE      = 6'd19;
   localparam logic [5:0] KIND_LT      = 6'd20;
   localparam logic [5:0] KIND_EQEQ    = 6'd21;
   localparam logic [5:0] KIND_ASSIGN  = 6'd22;
   localparam logic [5:0] KIND_NE      = 6'd23;
   localparam logic [5:0] KIND_NOT     = 6'd24;
   localparam logic [5:0] KIND_TILDE   = 6'd25;
   localparam logic [5:0] KIND_OROR    = 6'd26;
   localparam logic [5:0] KIND_OR      = 6'd27;
   localparam logic [5:0] KIND_ANDAND  = 6'd28;
   localparam logic [5:0] KIND_AND     = 6'd29;
   localparam logic [5:0] KIND_KW_BASE = 6'd30;
   localparam logic [5:0] KIND_IDENT   = 6'd38;
   localparam logic [5:0] KIND_NUMBER  = 6'd39;
   localparam logic [5:0] KIND_EOF     = 6'd40;
   localparam logic [5:0] KIND_ERROR   = 6'd41;

   // Scanner state codes: what kind of token is being collected.
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_OP    = 3'd1;
   localparam logic [2:0] MODE_ARROW = 3'd2;
   localparam logic [2:0] MODE_WORD  = 3'd3;
   localparam logic [2:0] MODE_NUM   = 3'd4;

   // Keywords, packed one character per byte with the last character lowest.
   localparam int NUM_KEYWORDS = 8;
   localparam logic [55:0] KW_TEXT [NUM_KEYWORDS] = '{
      56'h69_3332,            // i32
      56'h62_6F6F_6C,         // bool
      56'h70_6173_73,         // pass
      56'h77_6869_6C65,       // while
      56'h69_66,              // if
      56'h65_6C73_65,         // else
      56'h72_6574_7572_6E,    // return
      56'h73_7472_7563_74     // struct
   };
   localparam logic [RUN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
      RUN_W'(3), RUN_W'(4), RUN_W'(4), RUN_W'(5),
      RUN_W'(2), RUN_W'(4), RUN_W'(6), RUN_W'(6)
   };

   typedef struct packed {
      logic [5:0]       kind;
      logic [30:0]      value;
      logic [LEN_W-1:0] length;
      logic [15:0]      row;
      logic [15:0]      column;
      logic             too_long;
      logic             bad_numeral;
      logic             last_token;
   } lex_token_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [7:0]       pend_char;
      logic [55:0]      prefix;
      logic [RUN_W-1:0] run_len;
      logic [30:0]      acc;
      logic             num_sat;
      logic [15:0]      row;
      logic [15:0]      col;
      logic [15:0]      trow;
      logic [15:0]      tcol;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:      MODE_IDLE,
      pend_char: 8'd0,
      prefix:    56'd0,
      run_len:   '0,
      acc:       31'd0,
      num_sat:   1'b0,
      row:       16'd1,
      col:       16'd1,
      trow:      16'd1,
      tcol:      16'd1
   };

   function automatic logic is_alpha_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Kind of a one-character token.
   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         CHAR_SEMI:  k = KIND_SEMI;
         ":":        k = KIND_COLON;
         ",":        k = KIND_COMMA;
         "(":        k = KIND_LPAREN;
         ")":        k = KIND_RPAREN;
         "{":        k = KIND_LBRACE;
         "}":        k = KIND_RBRACE;
         "[":        k = KIND_LBRACK;
         "]":        k = KIND_RBRACK;
         CHAR_AT:    k = KIND_AT;
         CHAR_MINUS: k = KIND_MINUS;
         "+":        k = KIND_PLUS;
         "*":        k = KIND_STAR;
         "/":        k = KIND_SLASH;
         "%":        k = KIND_PERCENT;
         CHAR_GT:    k = KIND_GT;
         CHAR_LT:    k = KIND_LT;
         CHAR_EQ:    k = KIND_ASSIGN;
         CHAR_BANG:  k = KIND_NOT;
         CHAR_TILDE: k = KIND_TILDE;
         CHAR_PIPE:  k = KIND_OR;
         CHAR_AMP:   k = KIND_AND;
         default:    k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // Second character that completes a two-character operator.
   function automatic logic [8:0] pair_second(input logic [7:0] c);
      logic [8:0] s;
      unique case (c) inside
         CHAR_CARET: s = {1'b0, CHAR_CARET};
         CHAR_GT,
         CHAR_LT,
         CHAR_EQ,
         CHAR_BANG:  s = {1'b0, CHAR_EQ};
         CHAR_PIPE:  s = {1'b0, CHAR_PIPE};
         CHAR_AMP:   s = {1'b0, CHAR_AMP};
         default:    s = NO_PAIR;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         CHAR_CARET: k = KIND_XOR2;
         CHAR_GT:    k = KIND_GE;
         CHAR_LT:    k = KIND_LE;
         CHAR_EQ:    k = KIND_EQEQ;
         CHAR_BANG:  k = KIND_NE;
         CHAR_PIPE:  k = KIND_OROR;
         default:    k = KIND_ANDAND;
      endcase
      return k;
   endfunction

   // Keyword lookup on the packed tail of a word and its length.
   function automatic logic [5:0] word_kind(input logic [55:0] prefix,
                                            input logic [RUN_W-1:0] run_len);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (run_len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            k = KIND_KW_BASE + 6'(i);
         end
      end
      return k;
   endfunction

   function automatic lex_token_type make_token(input logic [5:0] kind,
                                                input logic [30:0] value,
                                                input logic [LEN_W-1:0] length,
                                                input logic [15:0] row,
                                                input logic [15:0] column,
                                                input logic tl,
                                                input logic bad,
                                                input logic last);
      lex_token_type t;
      t.kind        = kind;
      t.value       = value;
      t.length      = length;
      t.row         = row;
      t.column      = column;
      t.too_long    = tl;
      t.bad_numeral = bad;
      t.last_token  = last;
      return t;
   endfunction

   // Token for whatever is being collected; only meaningful when not idle.
   function automatic lex_token_type flush_token(input scan_state_type s, input logic bad);
      lex_token_type    t;
      logic [RUN_W-1:0] sat;
      logic             tl;
      tl  = s.run_len > RUN_LIMIT;
      sat = tl ? RUN_LIMIT : s.run_len;
      unique case (s.mode)
         MODE_OP:    t = make_token(single_kind(s.pend_char), 31'd0, LEN_W'(1),
                                    s.trow, s.tcol, 1'b0, 1'b0, 1'b0);
         MODE_ARROW: t = make_token(KIND_ARROW, s.acc, LEN_W'(sat),
                                    s.trow, s.tcol, tl, 1'b0, 1'b0);
         MODE_WORD:  t = make_token(word_kind(s.prefix, s.run_len), 31'd0, LEN_W'(sat),
                                    s.trow, s.tcol, tl, 1'b0, 1'b0);
         MODE_NUM:   t = make_token(KIND_NUMBER, s.acc, LEN_W'(sat),
                                    s.trow, s.tcol, tl | s.num_sat, bad, 1'b0);
         default:    t = '0;
      endcase
      return t;
   endfunction

   // Drop the token under collection, keeping the position counters.
   function automatic scan_state_type clear_pending(input scan_state_type s);
      scan_state_type r;
      r           = s;
      r.mode      = MODE_IDLE;
      r.pend_char = 8'd0;
      r.prefix    = 56'd0;
      r.run_len   = '0;
      r.acc       = 31'd0;
      r.num_sat   = 1'b0;
      return r;
   endfunction

   function automatic logic [RUN_W-1:0] bump_run(input logic [RUN_W-1:0] run_len);
      return (run_len <= RUN_LIMIT) ? run_len + RUN_W'(1) : run_len;
   endfunction

endpackage

/* rtl/source_token_scanner.sv */
// Source token scanner: one source byte per transfer in, tokens out.
// A token is on the result port in the cycle after the byte that completes it if no result
// waits ahead. Throughput: one byte per cycle while at most one result waits; a byte may
// raise up to three results, leaving a four-slot output buffer one per cycle unless stalled.
// Reset: synchronous, active high; scanner returns to row 1, column 1 with nothing pending.
`include "assert_macros.svh"

module source_token_scanner (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [30:0] rsp_token_value,
   output logic [6:0]  rsp_token_length,
   output logic [15:0] rsp_start_row,
   output logic [15:0] rsp_start_column,
   output logic        rsp_too_long,
   output logic        rsp_bad_numeral,
   output logic        rsp_last_token
);

   stsc_pkg::scan_state_type st_ff, st_in;
   stsc_pkg::lex_token_type  slot_ff [stsc_pkg::OUT_SLOTS];
   stsc_pkg::lex_token_type  slot_in [stsc_pkg::OUT_SLOTS];
   logic [stsc_pkg::CNT_W-1:0] count_ff, count_in;

   stsc_pkg::lex_token_type res [3];
   logic [1:0]          n_new;
   logic                req_accept;
   logic                rsp_pop;

   // A byte is taken only when the buffer has room for three new results.
   assign req_stall  = count_ff > stsc_pkg::CNT_W'(1);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = count_ff != '0;
   assign rsp_pop    = rsp_valid & ~rsp_stall;

   // Scanner step: the results of one byte and the state it leaves.
   always_comb begin
      stsc_pkg::scan_state_type s;
      logic [1:0]  n;
      logic        fresh;
      logic [7:0]  b;
      logic [15:0] r;
      logic [15:0] c;
      logic [3:0]  digit;
      logic [34:0] wide;

      s     = st_ff;
      n     = 2'd0;
      fresh = 1'b1;
      b     = req_byte_in;
      r     = st_ff.row;
      c     = st_ff.col;
      digit = 4'(b - stsc_pkg::CHAR_ZERO);
      wide  = '0;
      for (int i = 0; i < 3; i++) begin
         res[i] = '0;
      end

      if (b == stsc_pkg::CHAR_NUL) begin
         // End of source at this byte's position.
         if (s.mode != stsc_pkg::MODE_IDLE) begin
            res[n] = stsc_pkg::flush_token(s, 1'b0);
            n      = n + 2'd1;
         end
         res[n] = stsc_pkg::make_token(stsc_pkg::KIND_EOF, 31'd0, '0, r, c,
                                       1'b0, 1'b0, 1'b1);
         n      = n + 2'd1;
         s      = stsc_pkg::SCAN_RESET;
      end else begin
         // Extend the pending token, or send it and rescan the byte.
         unique case (s.mode)
            stsc_pkg::MODE_OP: begin
               if (s.pend_char == stsc_pkg::CHAR_MINUS && b == stsc_pkg::CHAR_GT) begin
                  s.mode    = stsc_pkg::MODE_ARROW;
                  s.acc     = 31'd1;
                  s.run_len = stsc_pkg::bump_run(s.run_len);
                  fresh     = 1'b0;
               end else if ({1'b0, b} == stsc_pkg::pair_second(s.pend_char)) begin
                  res[n] = stsc_pkg::make_token(stsc_pkg::pair_kind(s.pend_char), 31'd0,
                                                stsc_pkg::LEN_W'(2), s.trow, s.tcol,
                                                1'b0, 1'b0, 1'b0);
                  n      = n + 2'd1;
                  s      = stsc_pkg::clear_pending(s);
                  fresh  = 1'b0;
               end else begin
                  res[n] = stsc_pkg::flush_token(s, 1'b0);
                  n      = n + 2'd1;
                  s      = stsc_pkg::clear_pending(s);
               end
            end
            stsc_pkg::MODE_ARROW: begin
               if (b == stsc_pkg::CHAR_GT) begin
                  if (s.acc < stsc_pkg::VALUE_MAX) begin
                     s.acc = s.acc + 31'd1;
                  end
                  s.run_len = stsc_pkg::bump_run(s.run_len);
                  fresh     = 1'b0;
               end else begin
                  res[n] = stsc_pkg::flush_token(s, 1'b0);
                  n      = n + 2'd1;
                  s      = stsc_pkg::clear_pending(s);
               end
            end
            stsc_pkg::MODE_WORD: begin
               if (stsc_pkg::is_alpha_char(b) || stsc_pkg::is_digit(b)) begin
                  s.prefix  = {s.prefix[47:0], b};
                  s.run_len = stsc_pkg::bump_run(s.run_len);
                  fresh     = 1'b0;
               end else begin
                  res[n] = stsc_pkg::flush_token(s, 1'b0);
                  n      = n + 2'd1;
                  s      = stsc_pkg::clear_pending(s);
               end
            end
            stsc_pkg::MODE_NUM: begin
               if (stsc_pkg::is_digit(b)) begin
                  // Times ten as two shifts, then saturate.
                  wide = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + 35'(digit);
                  if (wide > 35'(stsc_pkg::VALUE_MAX)) begin
                     s.acc     = stsc_pkg::VALUE_MAX;
                     s.num_sat = 1'b1;
                  end else begin
                     s.acc = wide[30:0];
                  end
                  s.run_len = stsc_pkg::bump_run(s.run_len);
                  fresh     = 1'b0;
               end else begin
                  res[n] = stsc_pkg::flush_token(s, stsc_pkg::is_alpha_char(b));
                  n      = n + 2'd1;
                  s      = stsc_pkg::clear_pending(s);
               end
            end
            default: begin
            end
         endcase

         // Start a new token from this byte.
         if (fresh) begin
            if (b == stsc_pkg::CHAR_SPACE || b == stsc_pkg::CHAR_NEWLINE) begin
               s = s;
            end else if (b == stsc_pkg::CHAR_MINUS ||
                         stsc_pkg::pair_second(b) != stsc_pkg::NO_PAIR) begin
               s.mode      = stsc_pkg::MODE_OP;
               s.trow      = r;
               s.tcol      = c;
               s.run_len   = stsc_pkg::RUN_W'(1);
               s.pend_char = b;
            end else if (stsc_pkg::is_alpha_char(b)) begin
               s.mode    = stsc_pkg::MODE_WORD;
               s.trow    = r;
               s.tcol    = c;
               s.run_len = stsc_pkg::RUN_W'(1);
               s.prefix  = {48'd0, b};
            end else if (stsc_pkg::is_digit(b)) begin
               s.mode    = stsc_pkg::MODE_NUM;
               s.trow    = r;
               s.tcol    = c;
               s.run_len = stsc_pkg::RUN_W'(1);
               s.acc     = {27'd0, digit};
            end else begin
               res[n] = stsc_pkg::make_token(stsc_pkg::single_kind(b), 31'd0,
                                             stsc_pkg::LEN_W'(1), r, c,
                                             1'b0, 1'b0, 1'b0);
               n      = n + 2'd1;
            end
         end

         // Position tracking, saturating at the counter limit.
         if (b == stsc_pkg::CHAR_NEWLINE) begin
            if (s.row < stsc_pkg::POS_MAX) begin
               s.row = s.row + 16'd1;
            end
            s.col = 16'd1;
         end else if (s.col < stsc_pkg::POS_MAX) begin
            s.col = s.col + 16'd1;
         end

         // Final byte: close the source just after it.
         if (req_last_byte) begin
            if (s.mode != stsc_pkg::MODE_IDLE) begin
               res[n] = stsc_pkg::flush_token(s, 1'b0);
               n      = n + 2'd1;
            end
            res[n] = stsc_pkg::make_token(stsc_pkg::KIND_EOF, 31'd0, '0, s.row, s.col,
                                          1'b0, 1'b0, 1'b1);
            n      = n + 2'd1;
            s      = stsc_pkg::SCAN_RESET;
         end
      end

      st_in = req_accept ? s : st_ff;
      n_new = n;
   end

   // Output buffer: slot 0 drives the port, the rest shift down on each transfer out.
   always_comb begin
      logic [stsc_pkg::CNT_W-1:0] base;
      logic [stsc_pkg::CNT_W-1:0] offs;

      base = count_ff - stsc_pkg::CNT_W'(rsp_pop);
      for (int i = 0; i < stsc_pkg::OUT_SLOTS; i++) begin
         if (rsp_pop && i < stsc_pkg::OUT_SLOTS - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         offs = stsc_pkg::CNT_W'(i) - base;
         if (req_accept && stsc_pkg::CNT_W'(i) >= base &&
             offs < stsc_pkg::CNT_W'(n_new)) begin
            slot_in[i] = res[offs[1:0]];
         end
      end
      count_in = base + (req_accept ? stsc_pkg::CNT_W'(n_new) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= stsc_pkg::SCAN_RESET;
         count_ff <= '0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < stsc_pkg::OUT_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_token_kind   = slot_ff[0].kind;
   assign rsp_token_value  = slot_ff[0].value;
   assign rsp_token_length = slot_ff[0].length;
   assign rsp_start_row    = slot_ff[0].row;
   assign rsp_start_column = slot_ff[0].column;
   assign rsp_too_long     = slot_ff[0].too_long;
   assign rsp_bad_numeral  = slot_ff[0].bad_numeral;
   assign rsp_last_token   = slot_ff[0].last_token;

   // The buffer never holds more results than it has slots.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
                   count_ff <= stsc_pkg::CNT_W'(stsc_pkg::OUT_SLOTS))

   // An end token carries no length, and only end tokens are marked last.
   `ASSERT_IMPLIES(a_eof_shape, clock, reset, rsp_valid,
                   (rsp_last_token == (rsp_token_kind == stsc_pkg::KIND_EOF)) &&
                   (!rsp_last_token || rsp_token_length == '0))

   // After a final byte the scanner is back at its starting position.
   `ASSERT_NEXT(a_last_resets, clock, reset, req_accept && req_last_byte,
                st_ff.mode == stsc_pkg::MODE_IDLE && st_ff.row == 16'd1 &&
                st_ff.col == 16'd1)

   // With nothing pending the collection registers are clear.
   `ASSERT_IMPLIES(a_idle_clear, clock, reset, st_ff.mode == stsc_pkg::MODE_IDLE,
                   st_ff.run_len == '0 && st_ff.acc == 31'd0 && !st_ff.num_sat)

   // A result waiting at the port with no transfer out stays in the buffer.
   `ASSERT_NEXT(a_no_loss, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

/* dv/source_token_scanner_tb.sv */
module source_token_scanner_tb;

   localparam int CYCLE_LIMIT = 100_000;
   localparam int RANDOM_BYTES = 60;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_PRINTED_FAULTS = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [30:0] rsp_token_value;
   logic [6:0]  rsp_token_length;
   logic [15:0] rsp_start_row;
   logic [15:0] rsp_start_column;
   logic        rsp_too_long;
   logic        rsp_bad_numeral;
   logic        rsp_last_token;

   source_token_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_value  (rsp_token_value),
      .rsp_token_length (rsp_token_length),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_column (rsp_start_column),
      .rsp_too_long     (rsp_too_long),
      .rsp_bad_numeral  (rsp_bad_numeral),
      .rsp_last_token   (rsp_last_token)
   );

   always #5 clock = ~clock;

   // Tokens predicted but not yet seen on the result port, oldest first.
   stsc_pkg::lex_token_type tokens_due[$];
   int        fault_count = 0;
   int        cycle_count = 0;
   int        bytes_sent = 0;

   // Sender pacing: bursts of transfers, most of them separated by idle gaps.
   int        burst_left = 0;

   // Receiver pacing: a stall style that is picked anew whenever its run of cycles ends.
   int        stall_left = 0;
   int        stall_style = 0;

   string     single_ops = ";:,(){}[]@+*/%~-><=!|&^";
   string     pair_ops = ">=<===!=||&&^^";

   // Scanner state as the testbench tracks it.
   logic [2:0]  scan_mode;
   logic [7:0]  scan_char;
   logic [55:0] scan_tail;
   int          scan_run;
   logic [30:0] scan_acc;
   logic        scan_sat;
   logic [15:0] at_row;
   logic [15:0] at_col;
   logic [15:0] tok_row;
   logic [15:0] tok_col;

   // ---------------------------------------------------------------- prediction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_numeral(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [5:0] one_char_kind(input logic [7:0] b);
      logic [5:0] kind;
      case (b)
         stsc_pkg::CHAR_SEMI:  kind = stsc_pkg::KIND_SEMI;
         ":":                  kind = stsc_pkg::KIND_COLON;
         ",":                  kind = stsc_pkg::KIND_COMMA;
         "(":                  kind = stsc_pkg::KIND_LPAREN;
         ")":                  kind = stsc_pkg::KIND_RPAREN;
         "{":                  kind = stsc_pkg::KIND_LBRACE;
         "}":                  kind = stsc_pkg::KIND_RBRACE;
         "[":                  kind = stsc_pkg::KIND_LBRACK;
         "]":                  kind = stsc_pkg::KIND_RBRACK;
         stsc_pkg::CHAR_AT:    kind = stsc_pkg::KIND_AT;
         stsc_pkg::CHAR_MINUS: kind = stsc_pkg::KIND_MINUS;
         "+":                  kind = stsc_pkg::KIND_PLUS;
         "*":                  kind = stsc_pkg::KIND_STAR;
         "/":                  kind = stsc_pkg::KIND_SLASH;
         "%":                  kind = stsc_pkg::KIND_PERCENT;
         stsc_pkg::CHAR_GT:    kind = stsc_pkg::KIND_GT;
         stsc_pkg::CHAR_LT:    kind = stsc_pkg::KIND_LT;
         stsc_pkg::CHAR_EQ:    kind = stsc_pkg::KIND_ASSIGN;
         stsc_pkg::CHAR_BANG:  kind = stsc_pkg::KIND_NOT;
         stsc_pkg::CHAR_TILDE: kind = stsc_pkg::KIND_TILDE;
         stsc_pkg::CHAR_PIPE:  kind = stsc_pkg::KIND_OR;
         stsc_pkg::CHAR_AMP:   kind = stsc_pkg::KIND_AND;
         default:              kind = stsc_pkg::KIND_ERROR;
      endcase
      return kind;
   endfunction

   function automatic logic opens_pair(input logic [7:0] b);
      return b == stsc_pkg::CHAR_CARET || b == stsc_pkg::CHAR_GT ||
             b == stsc_pkg::CHAR_LT || b == stsc_pkg::CHAR_EQ ||
             b == stsc_pkg::CHAR_BANG || b == stsc_pkg::CHAR_PIPE ||
             b == stsc_pkg::CHAR_AMP;
   endfunction

   // Carets, pipes and ampersands pair with themselves; the comparisons take '='.
   function automatic logic pair_completes(input logic [7:0] first, input logic [7:0] second);
      logic hit;
      case (first) inside
         stsc_pkg::CHAR_CARET, stsc_pkg::CHAR_PIPE, stsc_pkg::CHAR_AMP:
            hit = (second == first);
         stsc_pkg::CHAR_GT, stsc_pkg::CHAR_LT, stsc_pkg::CHAR_EQ, stsc_pkg::CHAR_BANG:
            hit = (second == stsc_pkg::CHAR_EQ);
         default:
            hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [5:0] pair_kind_of(input logic [7:0] first);
      logic [5:0] kind;
      case (first)
         stsc_pkg::CHAR_CARET: kind = stsc_pkg::KIND_XOR2;
         stsc_pkg::CHAR_GT:    kind = stsc_pkg::KIND_GE;
         stsc_pkg::CHAR_LT:    kind = stsc_pkg::KIND_LE;
         stsc_pkg::CHAR_EQ:    kind = stsc_pkg::KIND_EQEQ;
         stsc_pkg::CHAR_BANG:  kind = stsc_pkg::KIND_NE;
         stsc_pkg::CHAR_PIPE:  kind = stsc_pkg::KIND_OROR;
         default:              kind = stsc_pkg::KIND_ANDAND;
      endcase
      return kind;
   endfunction

   function automatic string keyword_spelling(input int k);
      string s;
      case (k)
         0:       s = "i32";
         1:       s = "bool";
         2:       s = "pass";
         3:       s = "while";
         4:       s = "if";
         5:       s = "else";
         6:       s = "return";
         default: s = "struct";
      endcase
      return s;
   endfunction

   // A word is a keyword when its length and its last seven characters both agree.
   function automatic logic [5:0] word_kind_of();
      string       kw;
      logic [55:0] spelled;
      logic [5:0]  kind;
      int          k;
      int          j;
      kind = stsc_pkg::KIND_IDENT;
      for (k = 0; k < stsc_pkg::NUM_KEYWORDS; k++) begin
         kw = keyword_spelling(k);
         spelled = '0;
         for (j = 0; j < kw.len(); j++) begin
            spelled = {spelled[47:0], kw[j]};
         end
         if (scan_run == kw.len() && scan_tail == spelled) begin
            kind = stsc_pkg::KIND_KW_BASE + 6'(k);
         end
      end
      return kind;
   endfunction

   function automatic void push_token(input logic [5:0] kind, input logic [30:0] value,
                                      input int len, input logic [15:0] row,
                                      input logic [15:0] col, input logic tl,
                                      input logic bad, input logic fin);
      stsc_pkg::lex_token_type t;
      t.kind        = kind;
      t.value       = value;
      t.length      = 7'(len);
      t.row         = row;
      t.column      = col;
      t.too_long    = tl;
      t.bad_numeral = bad;
      t.last_token  = fin;
      tokens_due.push_back(t);
   endfunction

   function automatic void drop_pending();
      scan_mode = stsc_pkg::MODE_IDLE;
      scan_char = 8'd0;
      scan_tail = 56'd0;
      scan_run  = 0;
      scan_acc  = 31'd0;
      scan_sat  = 1'b0;
   endfunction

   function automatic void restart_scan();
      drop_pending();
      at_row  = 16'd1;
      at_col  = 16'd1;
      tok_row = 16'd1;
      tok_col = 16'd1;
   endfunction

   function automatic void grow_run();
      if (scan_run <= stsc_pkg::MAX_TOKEN_LENGTH) begin
         scan_run++;
      end
   endfunction

   function automatic void begin_token(input logic [2:0] mode, input logic [15:0] row,
                                       input logic [15:0] col);
      scan_mode = mode;
      tok_row   = row;
      tok_col   = col;
      scan_run  = 1;
   endfunction

   // Send out whatever token is being collected and return to idle.
   function automatic void flush_pending(input logic bad);
      logic tl;
      int   len;
      tl  = scan_run > stsc_pkg::MAX_TOKEN_LENGTH;
      len = tl ? stsc_pkg::MAX_TOKEN_LENGTH : scan_run;
      case (scan_mode)
         stsc_pkg::MODE_OP:
            push_token(one_char_kind(scan_char), 31'd0, 1, tok_row, tok_col,
                       1'b0, 1'b0, 1'b0);
         stsc_pkg::MODE_ARROW:
            push_token(stsc_pkg::KIND_ARROW, scan_acc, len, tok_row, tok_col,
                       tl, 1'b0, 1'b0);
         stsc_pkg::MODE_WORD:
            push_token(word_kind_of(), 31'd0, len, tok_row, tok_col, tl, 1'b0, 1'b0);
         stsc_pkg::MODE_NUM:
            push_token(stsc_pkg::KIND_NUMBER, scan_acc, len, tok_row, tok_col,
                       tl | scan_sat, bad, 1'b0);
         default: ;
      endcase
      drop_pending();
   endfunction

   // Work out the tokens that one accepted byte releases.
   function automatic void scan_byte(input logic [7:0] b, input logic fin);
      logic [15:0] row;
      logic [15:0] col;
      logic        fresh;
      logic [63:0] wide;
      row   = at_row;
      col   = at_col;
      fresh = 1'b1;

      // A zero byte ends the source at its own position.
      if (b == stsc_pkg::CHAR_NUL) begin
         flush_pending(1'b0);
         push_token(stsc_pkg::KIND_EOF, 31'd0, 0, row, col, 1'b0, 1'b0, 1'b1);
         restart_scan();
         return;
      end

      // Try to extend the token under collection.
      case (scan_mode)
         stsc_pkg::MODE_OP: begin
            if (scan_char == stsc_pkg::CHAR_MINUS && b == stsc_pkg::CHAR_GT) begin
               scan_mode = stsc_pkg::MODE_ARROW;
               scan_acc  = 31'd1;
               grow_run();
               fresh = 1'b0;
            end else if (pair_completes(scan_char, b)) begin
               push_token(pair_kind_of(scan_char), 31'd0, 2, tok_row, tok_col,
                          1'b0, 1'b0, 1'b0);
               drop_pending();
               fresh = 1'b0;
            end else begin
               flush_pending(1'b0);
            end
         end
         stsc_pkg::MODE_ARROW: begin
            if (b == stsc_pkg::CHAR_GT) begin
               if (scan_acc != stsc_pkg::VALUE_MAX) begin
                  scan_acc++;
               end
               grow_run();
               fresh = 1'b0;
            end else begin
               flush_pending(1'b0);
            end
         end
         stsc_pkg::MODE_WORD: begin
            if (is_alpha(b) || is_numeral(b)) begin
               scan_tail = {scan_tail[47:0], b};
               grow_run();
               fresh = 1'b0;
            end else begin
               flush_pending(1'b0);
            end
         end
         stsc_pkg::MODE_NUM: begin
            if (is_numeral(b)) begin
               wide = 64'(scan_acc) * 64'd10 + 64'(b - stsc_pkg::CHAR_ZERO);
               if (wide > 64'(stsc_pkg::VALUE_MAX)) begin
                  wide     = 64'(stsc_pkg::VALUE_MAX);
                  scan_sat = 1'b1;
               end
               scan_acc = wide[30:0];
               grow_run();
               fresh = 1'b0;
            end else begin
               flush_pending(is_alpha(b));
            end
         end
         default: ;
      endcase

      // Otherwise the byte starts something new, unless it is whitespace.
      if (fresh && b != stsc_pkg::CHAR_SPACE && b != stsc_pkg::CHAR_NEWLINE) begin
         if (b == stsc_pkg::CHAR_MINUS || opens_pair(b)) begin
            begin_token(stsc_pkg::MODE_OP, row, col);
            scan_char = b;
         end else if (is_alpha(b)) begin
            begin_token(stsc_pkg::MODE_WORD, row, col);
            scan_tail = 56'(b);
         end else if (is_numeral(b)) begin
            begin_token(stsc_pkg::MODE_NUM, row, col);
            scan_acc = 31'(b - stsc_pkg::CHAR_ZERO);
         end else begin
            push_token(one_char_kind(b), 31'd0, 1, row, col, 1'b0, 1'b0, 1'b0);
         end
      end

      // Position counters saturate rather than wrap.
      if (b == stsc_pkg::CHAR_NEWLINE) begin
         if (at_row != stsc_pkg::POS_MAX) begin
            at_row++;
         end
         at_col = 16'd1;
      end else if (at_col != stsc_pkg::POS_MAX) begin
         at_col++;
      end

      // The final byte ends the source at the position after it.
      if (fin) begin
         flush_pending(1'b0);
         push_token(stsc_pkg::KIND_EOF, 31'd0, 0, at_row, at_col, 1'b0, 1'b0, 1'b1);
         restart_scan();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_PRINTED_FAULTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input logic [5:0] kind);
      if (got !== want) begin
         report_fault($sformatf("%s of token kind %0d: got %0d, expected %0d",
                                name, kind, got, want));
      end
   endtask

   // Each result transfer is compared with the oldest predicted token.
   always @(posedge clock) begin : check_tokens
      stsc_pkg::lex_token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report_fault($sformatf("unexpected token kind %0d at row %0d column %0d",
                                   rsp_token_kind, rsp_start_row, rsp_start_column));
         end else begin
            want = tokens_due.pop_front();
            check_field("kind", rsp_token_kind, want.kind, want.kind);
            check_field("value", rsp_token_value, want.value, want.kind);
            check_field("length", rsp_token_length, want.length, want.kind);
            check_field("start row", rsp_start_row, want.row, want.kind);
            check_field("start column", rsp_start_column, want.column, want.kind);
            check_field("too_long", rsp_too_long, want.too_long, want.kind);
            check_field("bad_numeral", rsp_bad_numeral, want.bad_numeral, want.kind);
            check_field("last_token", rsp_last_token, want.last_token, want.kind);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** source_token_scanner: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // Receiver stall pattern: free running, coin toss, mostly stalled, or periodic.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_style)
         0:       rsp_stall = 1'b0;
         1:       rsp_stall = ($urandom_range(0, 1) == 1);
         2:       rsp_stall = ($urandom_range(0, 4) != 0);
         default: rsp_stall = ((stall_left % 5) < 2);
      endcase
   end

   // One byte transfer; the prediction is made at the edge that accepts it.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int pause;
      pause = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (pause > 0) begin
         req_valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_byte_in   = b;
      req_last_byte = fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scan_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i], 1'b0);
      end
   endtask

   // Hold the sender off until every predicted token has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = ($urandom_range(0, 1) == 0) ? "a" : "A";
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return stsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_alnum();
      return ($urandom_range(0, 3) == 0) ? random_digit() : random_letter();
   endfunction

   // ---------------------------------------------------------------- tests

   // Every single and double operator, the arrow, and a lone caret.
   task automatic test_operators();
      send_text(";:,(){}[]@+*/%~- > >= < <= = == ! != | || & && ^^ ^ ->>> -> =>=!!=");
      send_byte(stsc_pkg::CHAR_NUL, 1'b0);
   endtask

   // Every keyword, near misses, and the number extremes including a letter after digits.
   task automatic test_words_numbers();
      send_text("i32 bool pass while if else return struct iff If ab7 ");
      send_text("0 2147483647 2147483648 9x ");
      send_byte(stsc_pkg::CHAR_SEMI, 1'b1);
   endtask

   // A word, a number and an arrow each just past the length limit.
   task automatic test_long_runs();
      send_byte(random_letter(), 1'b0);
      repeat (stsc_pkg::MAX_TOKEN_LENGTH) send_byte(random_alnum(), 1'b0);
      send_byte(stsc_pkg::CHAR_NEWLINE, 1'b0);
      repeat (stsc_pkg::MAX_TOKEN_LENGTH + 1) send_byte(random_digit(), 1'b0);
      send_byte(stsc_pkg::CHAR_SPACE, 1'b0);
      send_byte(stsc_pkg::CHAR_MINUS, 1'b0);
      repeat (stsc_pkg::MAX_TOKEN_LENGTH + 1) send_byte(stsc_pkg::CHAR_GT, 1'b0);
      send_byte(stsc_pkg::CHAR_NUL, 1'b0);
   endtask

   // Bytes that name no token: tab, carriage return, underscore, other control bytes, high values.
   task automatic test_odd_bytes();
      send_byte(8'h09, 1'b0);
      send_byte(8'h0D, 1'b0);
      send_byte("_", 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_text("^;");
   endtask

   // The two ways of ending a source, alone and together, with tokens pending.
   task automatic test_end_markers();
      wait_drained();
      send_text("ab");
      send_byte(stsc_pkg::CHAR_NUL, 1'b0);
      send_text("12");
      send_byte("3", 1'b1);
      send_byte(stsc_pkg::CHAR_LT, 1'b0);
      send_byte(stsc_pkg::CHAR_NUL, 1'b1);
      send_byte("x", 1'b0);
      send_byte(stsc_pkg::CHAR_NEWLINE, 1'b1);
      // An operator, a number and the end token all from the one byte.
      send_byte(stsc_pkg::CHAR_LT, 1'b0);
      send_byte("5", 1'b1);
      send_byte(stsc_pkg::CHAR_SEMI, 1'b1);
      wait_drained();
   endtask

   // Mostly well-formed tokens with random content, plus noise and abrupt ends.
   task automatic test_random_source();
      int   first_byte;
      int   pick;
      int   n;
      int   i;
      logic drained_once;
      first_byte   = bytes_sent;
      drained_once = 1'b0;
      while (bytes_sent - first_byte < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            send_text(keyword_spelling($urandom_range(0, stsc_pkg::NUM_KEYWORDS - 1)));
            if ($urandom_range(0, 4) == 0) begin
               send_byte(random_alnum(), 1'b0);
            end
         end else if (pick < 28) begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 9);
            send_byte(random_letter(), 1'b0);
            repeat (n - 1) send_byte(random_alnum(), 1'b0);
         end else if (pick < 42) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
            repeat (n) send_byte(random_digit(), 1'b0);
            if ($urandom_range(0, 4) == 0) begin
               send_byte(random_letter(), 1'b0);
            end
         end else if (pick < 62) begin
            if ($urandom_range(0, 1) == 0) begin
               send_byte(single_ops[$urandom_range(0, single_ops.len() - 1)], 1'b0);
            end else begin
               i = 2 * $urandom_range(0, pair_ops.len() / 2 - 1);
               send_byte(pair_ops[i], 1'b0);
               send_byte(pair_ops[i + 1], 1'b0);
            end
         end else if (pick < 70) begin
            send_byte(stsc_pkg::CHAR_MINUS, 1'b0);
            repeat ($urandom_range(1, 5)) send_byte(stsc_pkg::CHAR_GT, 1'b0);
         end else if (pick < 80) begin
            send_byte(($urandom_range(0, 2) == 0) ? stsc_pkg::CHAR_NEWLINE
                                                   : stsc_pkg::CHAR_SPACE, 1'b0);
         end else if (pick < 92) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
         end else if (pick < 97) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_byte(stsc_pkg::CHAR_NUL, 1'($urandom_range(0, 1)));
         end

         // Separator, or none so that neighbouring tokens meet.
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            send_byte(stsc_pkg::CHAR_SPACE, 1'b0);
         end else if (pick == 5) begin
            send_byte(stsc_pkg::CHAR_NEWLINE, 1'b0);
         end

         if (!drained_once && bytes_sent - first_byte >= RANDOM_BYTES / 2) begin
            wait_drained();
            drained_once = 1'b1;
         end
      end
      send_byte(stsc_pkg::CHAR_NUL, 1'b0);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      restart_scan();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_operators();
      test_words_numbers();
      test_long_runs();
      test_odd_bytes();
      test_end_markers();
      test_random_source();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("** source_token_scanner: PASSED **");
      end else begin
         $display("** source_token_scanner: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/stsc_pkg.sv
rtl/source_token_scanner.sv
dv/source_token_scanner_tb.sv
